// File: rtl/core/i2cwrs_pkg.sv
// shared types and constants for the i2c write-then-read sequencer
// holds the phase and command codes, the item/result/state structs and the length cap
// no dependencies

package i2cwrs_pkg;

    // longest transfer the block accepts, capped to what an eight-bit count holds
    localparam int MAX_LEN = 255;
    localparam logic [7:0] LEN_CAP = (MAX_LEN > 255) ? 8'd255 : 8'(MAX_LEN);

    // read/write bit set in the address byte for the read part
    localparam logic [7:0] RW_READ_BIT = 8'h01;

    // sequencer phase
    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_WRITE_NEXT  = 3'd1,
        PH_WRITE_FINAL = 3'd2,
        PH_READ_ONE    = 3'd3,
        PH_READ_FIRST  = 3'd4,
        PH_READ_NEXT   = 3'd5,
        PH_READ_FINAL  = 3'd6,
        PH_READ_WAIT   = 3'd7
    } t_phase;

    // command issued to the bus controller
    typedef enum logic [3:0] {
        CMD_NONE       = 4'd0,
        CMD_SEND_ONE   = 4'd1,
        CMD_SEND_START = 4'd2,
        CMD_SEND_CONT  = 4'd3,
        CMD_SEND_FIN   = 4'd4,
        CMD_RX_ONE     = 4'd5,
        CMD_RX_START   = 4'd6,
        CMD_RX_CONT    = 4'd7,
        CMD_RX_FIN     = 4'd8
    } t_cmd;

    // item function code
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_EVENT = 1'b1;

    // one input beat
    typedef struct packed {
        logic       func;
        logic [6:0] slave_addr;
        logic [7:0] tx_count;
        logic [7:0] rx_count;
        logic [7:0] tx_byte;
        logic [7:0] rx_data;
        logic       bus_error;
        logic       arb_lost;
    } t_item;

    // one result beat
    typedef struct packed {
        t_cmd       command;
        logic [7:0] data_out;
        logic [7:0] addr_out;
        logic       addr_write;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       err_bus;
        logic       err_arb;
    } t_result;

    // sequencer state, error bit 0 is bus error, bit 1 lost arbitration
    typedef struct packed {
        t_phase     phase;
        logic [7:0] tx_left;
        logic [7:0] rx_left;
        logic [7:0] addr;
        logic [1:0] err;
    } t_state;

endpackage

// File: rtl/core/i2c_write_read_sequencer.sv
// I2C write-then-read sequencer: one start or completion beat in, one command beat out.
// Each accepted beat lands in an input register. Once the output register is free or
// being emptied, it is evaluated against the sequencer state and its result is written
// to the output register, from which it is offered. Each item takes a single pass through
// the step logic, so one beat per cycle is sustained while the output side takes beats.
// While a result waits, the input register can still take one more beat if it is empty,
// so both sides can stall independently. Depends on i2cwrs_pkg and i2cwrs_step.

module i2c_write_read_sequencer import i2cwrs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_func,
    input  logic [6:0] i_slave_addr,
    input  logic [7:0] i_tx_count,
    input  logic [7:0] i_rx_count,
    input  logic [7:0] i_tx_byte,
    input  logic [7:0] i_rx_data,
    input  logic       i_bus_error,
    input  logic       i_arb_lost,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_command,
    output logic [7:0] o_data_out,
    output logic [7:0] o_addr_out,
    output logic       o_addr_write,
    output logic       o_rx_valid,
    output logic [7:0] o_rx_byte,
    output logic       o_done_res,
    output logic       o_err_bus,
    output logic       o_err_arb
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_res;
    t_state  r_state;
    t_state  n_state;
    t_result n_res;
    logic    w_move;

    // a held beat moves on when the output register is free or being emptied
    assign w_move     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_move;

    // step logic
    i2cwrs_step u_step (
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= '{func: i_func, slave_addr: i_slave_addr, tx_count: i_tx_count,
                      rx_count: i_rx_count, tx_byte: i_tx_byte, rx_data: i_rx_data,
                      bus_error: i_bus_error, arb_lost: i_arb_lost};
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, tx_left: 8'd0, rx_left: 8'd0,
                         addr: 8'd0, err: 2'b00};
        end else if (w_move) begin
            r_state <= n_state;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_command    = r_res.command;
    assign o_data_out   = r_res.data_out;
    assign o_addr_out   = r_res.addr_out;
    assign o_addr_write = r_res.addr_write;
    assign o_rx_valid   = r_res.rx_valid;
    assign o_rx_byte    = r_res.rx_byte;
    assign o_done_res   = r_res.done_res;
    assign o_err_bus    = r_res.err_bus;
    assign o_err_arb    = r_res.err_arb;

    // a finished transaction never carries a command
    a_done_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.done_res) |-> (r_res.command == CMD_NONE))
        else $error("done beat carries a command");

    // the address is written only with commands that open a bus phase
    a_addr_with_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.addr_write) |->
            (r_res.command == CMD_SEND_ONE || r_res.command == CMD_SEND_START ||
             r_res.command == CMD_RX_ONE   || r_res.command == CMD_RX_START))
        else $error("address write without an opening command");

    // received bytes only come back on receive steps or at the end
    a_rx_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.rx_valid) |->
            (r_res.command == CMD_RX_CONT || r_res.command == CMD_RX_FIN ||
             r_res.done_res))
        else $error("received byte outside the read phase");

    // a recorded error always leaves the sequencer idle
    a_err_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.err != 2'b00) |-> (r_state.phase == PH_IDLE))
        else $error("error set while sequence still running");

    // a beat that moves on always leaves a result behind
    a_move_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> r_out_valid)
        else $error("moved beat lost its result");

endmodule

// File: rtl/core/i2cwrs_step.sv
// next-state and result logic of the i2c write-then-read sequencer
// pure combinational: one item against the current state
// depends on i2cwrs_pkg

module i2cwrs_step import i2cwrs_pkg::*; (
    input  t_state  i_state,
    input  t_item   i_item,
    output t_state  o_state,
    output t_result o_result
);

    // phase once the last write byte has gone out
    function automatic t_phase after_write(input logic [7:0] rx_left);
        t_phase ph;
        if (rx_left == 8'd0) begin
            ph = PH_IDLE;
        end else if (rx_left == 8'd1) begin
            ph = PH_READ_ONE;
        end else begin
            ph = PH_READ_FIRST;
        end
        return ph;
    endfunction

    // clamp a length to the cap
    function automatic logic [7:0] clamp_len(input logic [7:0] v);
        return (v > LEN_CAP) ? LEN_CAP : v;
    endfunction

    // decrement that stops at zero
    function automatic logic [7:0] dec_sat(input logic [7:0] v);
        return (v != 8'd0) ? v - 8'd1 : v;
    endfunction

    logic [7:0] w_tc;
    logic [7:0] w_read_addr;

    assign w_read_addr = i_state.addr | RW_READ_BIT;

    // one step of the sequence
    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_result.command = CMD_NONE;
        w_tc = clamp_len(i_item.tx_count);
        if (w_tc == 8'd0) begin
            w_tc = 8'd1;
        end

        if (i_item.func == FUNC_START) begin
            // open a new transaction, dropping any running one
            o_state.rx_left      = clamp_len(i_item.rx_count);
            o_state.err          = 2'b00;
            o_state.addr         = {i_item.slave_addr, 1'b0};
            o_result.addr_write  = 1'b1;
            o_result.addr_out    = {i_item.slave_addr, 1'b0};
            o_result.data_out    = i_item.tx_byte;
            if (w_tc == 8'd1) begin
                o_state.phase    = after_write(o_state.rx_left);
                o_result.command = CMD_SEND_ONE;
            end else begin
                o_state.phase    = (w_tc == 8'd2) ? PH_WRITE_FINAL : PH_WRITE_NEXT;
                o_result.command = CMD_SEND_START;
            end
            o_state.tx_left = w_tc - 8'd1;
        end else begin
            // completion event: fold in errors, then advance
            o_state.err = i_state.err | {i_item.arb_lost, i_item.bus_error};
            if (o_state.err != 2'b00) begin
                o_state.phase     = PH_IDLE;
                o_result.done_res = 1'b1;
            end else begin
                unique case (i_state.phase)
                    PH_WRITE_NEXT: begin
                        if (i_state.tx_left <= 8'd2) begin
                            o_state.phase = PH_WRITE_FINAL;
                        end
                        o_result.data_out = i_item.tx_byte;
                        o_result.command  = CMD_SEND_CONT;
                        o_state.tx_left   = dec_sat(i_state.tx_left);
                    end
                    PH_WRITE_FINAL: begin
                        o_state.phase     = after_write(i_state.rx_left);
                        o_result.data_out = i_item.tx_byte;
                        o_result.command  = CMD_SEND_FIN;
                        o_state.tx_left   = dec_sat(i_state.tx_left);
                    end
                    PH_READ_ONE: begin
                        o_state.phase       = PH_READ_WAIT;
                        o_state.addr        = w_read_addr;
                        o_result.addr_write = 1'b1;
                        o_result.addr_out   = w_read_addr;
                        o_state.rx_left     = dec_sat(i_state.rx_left);
                        o_result.command    = CMD_RX_ONE;
                    end
                    PH_READ_FIRST: begin
                        o_state.phase = (i_state.rx_left <= 8'd2) ? PH_READ_FINAL
                                                                  : PH_READ_NEXT;
                        o_state.addr        = w_read_addr;
                        o_result.addr_write = 1'b1;
                        o_result.addr_out   = w_read_addr;
                        o_state.rx_left     = dec_sat(i_state.rx_left);
                        o_result.command    = CMD_RX_START;
                    end
                    PH_READ_NEXT: begin
                        if (i_state.rx_left <= 8'd2) begin
                            o_state.phase = PH_READ_FINAL;
                        end
                        o_result.rx_valid = 1'b1;
                        o_result.rx_byte  = i_item.rx_data;
                        o_state.rx_left   = dec_sat(i_state.rx_left);
                        o_result.command  = CMD_RX_CONT;
                    end
                    PH_READ_FINAL: begin
                        o_state.phase     = PH_READ_WAIT;
                        o_result.rx_valid = 1'b1;
                        o_result.rx_byte  = i_item.rx_data;
                        o_state.rx_left   = dec_sat(i_state.rx_left);
                        o_result.command  = CMD_RX_FIN;
                    end
                    PH_READ_WAIT: begin
                        o_state.phase     = PH_IDLE;
                        o_result.rx_valid = 1'b1;
                        o_result.rx_byte  = i_item.rx_data;
                        o_result.done_res = 1'b1;
                    end
                    PH_IDLE: begin
                        o_state.phase     = PH_IDLE;
                        o_result.done_res = 1'b1;
                    end
                endcase
            end
        end

        // sticky flags go out with every result
        o_result.err_bus = o_state.err[0];
        o_result.err_arb = o_state.err[1];
    end

endmodule

// File: verif/i2cwrs_checker.sv
// result checker for the i2c write-then-read sequencer: watches both channels,
// predicts each command beat from the accepted input beats and compares in order
// depends on i2cwrs_pkg

module i2cwrs_checker import i2cwrs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_func,
    input  logic [6:0] i_slave_addr,
    input  logic [7:0] i_tx_count,
    input  logic [7:0] i_rx_count,
    input  logic [7:0] i_tx_byte,
    input  logic [7:0] i_rx_data,
    input  logic       i_bus_error,
    input  logic       i_arb_lost,
    // output channel
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [3:0] i_command,
    input  logic [7:0] i_data_out,
    input  logic [7:0] i_addr_out,
    input  logic       i_addr_write,
    input  logic       i_rx_valid,
    input  logic [7:0] i_rx_byte,
    input  logic       i_done_res,
    input  logic       i_err_bus,
    input  logic       i_err_arb,
    // status towards the testbench top
    output int         o_fail_count,
    output int         o_pending
);

    // shadow copy of the sequencer state
    t_phase     seq_phase;
    logic [7:0] tx_left;
    logic [7:0] rx_left;
    logic [7:0] addr_byte;
    logic [1:0] err_flags;

    // commands still owed by the block, oldest first
    t_result    expected_cmds[$];

    // where the sequence goes once the last write byte is sent
    function automatic t_phase phase_after_send();
        if (rx_left == 8'd0) return PH_IDLE;
        if (rx_left == 8'd1) return PH_READ_ONE;
        return PH_READ_FIRST;
    endfunction

    // one step of the sequencer: updates the shadow state, returns the command beat
    function automatic t_result next_command(input t_item it);
        t_result    r;
        logic [7:0] tc;
        r = '0;
        r.command = CMD_NONE;
        if (it.func == FUNC_START) begin
            // a start drops whatever was running
            tc = (it.tx_count > LEN_CAP) ? LEN_CAP : it.tx_count;
            if (tc == 8'd0) tc = 8'd1;
            rx_left = (it.rx_count > LEN_CAP) ? LEN_CAP : it.rx_count;
            err_flags = 2'b00;
            addr_byte = {it.slave_addr, 1'b0};
            r.addr_write = 1'b1;
            r.addr_out = addr_byte;
            r.data_out = it.tx_byte;
            if (tc == 8'd1) begin
                seq_phase = phase_after_send();
                r.command = CMD_SEND_ONE;
            end else begin
                seq_phase = (tc == 8'd2) ? PH_WRITE_FINAL : PH_WRITE_NEXT;
                r.command = CMD_SEND_START;
            end
            tx_left = tc - 8'd1;
        end else begin
            // errors stick until the next start
            err_flags = err_flags | {it.arb_lost, it.bus_error};
            if (err_flags != 2'b00) begin
                seq_phase = PH_IDLE;
                r.done_res = 1'b1;
            end else begin
                case (seq_phase)
                    PH_WRITE_NEXT: begin
                        if (tx_left <= 8'd2) seq_phase = PH_WRITE_FINAL;
                        r.data_out = it.tx_byte;
                        r.command = CMD_SEND_CONT;
                        if (tx_left != 8'd0) tx_left = tx_left - 8'd1;
                    end
                    PH_WRITE_FINAL: begin
                        seq_phase = phase_after_send();
                        r.data_out = it.tx_byte;
                        r.command = CMD_SEND_FIN;
                        if (tx_left != 8'd0) tx_left = tx_left - 8'd1;
                    end
                    PH_READ_ONE, PH_READ_FIRST: begin
                        // restart in read mode
                        if (seq_phase == PH_READ_ONE) begin
                            seq_phase = PH_READ_WAIT;
                            r.command = CMD_RX_ONE;
                        end else begin
                            seq_phase = (rx_left <= 8'd2) ? PH_READ_FINAL : PH_READ_NEXT;
                            r.command = CMD_RX_START;
                        end
                        addr_byte = addr_byte | RW_READ_BIT;
                        r.addr_write = 1'b1;
                        r.addr_out = addr_byte;
                        if (rx_left != 8'd0) rx_left = rx_left - 8'd1;
                    end
                    PH_READ_NEXT: begin
                        if (rx_left <= 8'd2) seq_phase = PH_READ_FINAL;
                        r.rx_valid = 1'b1;
                        r.rx_byte = it.rx_data;
                        r.command = CMD_RX_CONT;
                        if (rx_left != 8'd0) rx_left = rx_left - 8'd1;
                    end
                    PH_READ_FINAL: begin
                        seq_phase = PH_READ_WAIT;
                        r.rx_valid = 1'b1;
                        r.rx_byte = it.rx_data;
                        r.command = CMD_RX_FIN;
                        if (rx_left != 8'd0) rx_left = rx_left - 8'd1;
                    end
                    PH_READ_WAIT: begin
                        seq_phase = PH_IDLE;
                        r.rx_valid = 1'b1;
                        r.rx_byte = it.rx_data;
                        r.done_res = 1'b1;
                    end
                    default: begin
                        // event with nothing running
                        seq_phase = PH_IDLE;
                        r.done_res = 1'b1;
                    end
                endcase
            end
        end
        r.err_bus = err_flags[0];
        r.err_arb = err_flags[1];
        return r;
    endfunction

    function automatic string show(input t_result r);
        return $sformatf("cmd=%0d data=%02h addr=%02h aw=%0d rxv=%0d rxb=%02h done=%0d eb=%0d ea=%0d",
                         r.command, r.data_out, r.addr_out, r.addr_write, r.rx_valid,
                         r.rx_byte, r.done_res, r.err_bus, r.err_arb);
    endfunction

    // output beat checked before the input beat of the same edge is queued
    always @(posedge i_clk) begin
        t_item   beat;
        t_result got;
        t_result exp;
        logic    bad;
        if (!i_rst_n) begin
            seq_phase = PH_IDLE;
            tx_left = 8'd0;
            rx_left = 8'd0;
            addr_byte = 8'd0;
            err_flags = 2'b00;
            expected_cmds.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.command = t_cmd'(i_command);
                got.data_out = i_data_out;
                got.addr_out = i_addr_out;
                got.addr_write = i_addr_write;
                got.rx_valid = i_rx_valid;
                got.rx_byte = i_rx_byte;
                got.done_res = i_done_res;
                got.err_bus = i_err_bus;
                got.err_arb = i_err_arb;
                if (expected_cmds.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected command beat: %s", show(got));
                    o_fail_count = o_fail_count + 1;
                end else begin
                    exp = expected_cmds.pop_front();
                    bad = (got.command    !== exp.command)    ||
                          (got.data_out   !== exp.data_out)   ||
                          (got.addr_out   !== exp.addr_out)   ||
                          (got.addr_write !== exp.addr_write) ||
                          (got.rx_valid   !== exp.rx_valid)   ||
                          (got.rx_byte    !== exp.rx_byte)    ||
                          (got.done_res   !== exp.done_res)   ||
                          (got.err_bus    !== exp.err_bus)    ||
                          (got.err_arb    !== exp.err_arb);
                    if (bad) begin
                        if (o_fail_count < 10) begin
                            $display("command mismatch at %0t", $realtime);
                            $display("  expected %s", show(exp));
                            $display("  actual   %s", show(got));
                        end
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                beat.func = i_func;
                beat.slave_addr = i_slave_addr;
                beat.tx_count = i_tx_count;
                beat.rx_count = i_rx_count;
                beat.tx_byte = i_tx_byte;
                beat.rx_data = i_rx_data;
                beat.bus_error = i_bus_error;
                beat.arb_lost = i_arb_lost;
                expected_cmds.push_back(next_command(beat));
            end
        end
        o_pending = expected_cmds.size();
    end

endmodule

// File: verif/i2c_write_read_sequencer_tb.sv
// testbench top for the i2c write-then-read sequencer: clock, reset, beat stimulus
// with random idling on both channels, and the final verdict
// depends on i2cwrs_pkg, i2c_write_read_sequencer and i2cwrs_checker

module i2c_write_read_sequencer_tb;
    import i2cwrs_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_BEATS = 550;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_item      beat_in = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [3:0] command;
    logic [7:0] data_out;
    logic [7:0] addr_out;
    logic       addr_write;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       err_bus;
    logic       err_arb;

    int         fail_count;
    int         pending;
    int         beats_sent = 0;
    int         cycle_count = 0;
    int         out_hold = 0;
    logic       calm = 1'b0;

    // clock
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    i2c_write_read_sequencer u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_func       (beat_in.func),
        .i_slave_addr (beat_in.slave_addr),
        .i_tx_count   (beat_in.tx_count),
        .i_rx_count   (beat_in.rx_count),
        .i_tx_byte    (beat_in.tx_byte),
        .i_rx_data    (beat_in.rx_data),
        .i_bus_error  (beat_in.bus_error),
        .i_arb_lost   (beat_in.arb_lost),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_command    (command),
        .o_data_out   (data_out),
        .o_addr_out   (addr_out),
        .o_addr_write (addr_write),
        .o_rx_valid   (rx_valid),
        .o_rx_byte    (rx_byte),
        .o_done_res   (done_res),
        .o_err_bus    (err_bus),
        .o_err_arb    (err_arb)
    );

    i2cwrs_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_func       (beat_in.func),
        .i_slave_addr (beat_in.slave_addr),
        .i_tx_count   (beat_in.tx_count),
        .i_rx_count   (beat_in.rx_count),
        .i_tx_byte    (beat_in.tx_byte),
        .i_rx_data    (beat_in.rx_data),
        .i_bus_error  (beat_in.bus_error),
        .i_arb_lost   (beat_in.arb_lost),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_command    (command),
        .i_data_out   (data_out),
        .i_addr_out   (addr_out),
        .i_addr_write (addr_write),
        .i_rx_valid   (rx_valid),
        .i_rx_byte    (rx_byte),
        .i_done_res   (done_res),
        .i_err_bus    (err_bus),
        .i_err_arb    (err_arb),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // transfer length: mostly small, a few up to the cap
    function automatic logic [7:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return 8'($urandom_range(0, 6));
        if (r < 97) return 8'($urandom_range(7, 40));
        return 8'($urandom_range(41, 255));
    endfunction

    function automatic t_item start_beat(input logic [6:0] addr, input logic [7:0] txc,
                                         input logic [7:0] rxc, input logic [7:0] txb);
        t_item it;
        it.func = FUNC_START;
        it.slave_addr = addr;
        it.tx_count = txc;
        it.rx_count = rxc;
        it.tx_byte = txb;
        it.rx_data = 8'($urandom);
        it.bus_error = 1'($urandom);
        it.arb_lost = 1'($urandom);
        return it;
    endfunction

    // completion event; start-only fields carry noise
    function automatic t_item event_beat(input logic [7:0] rxd, input logic be,
                                         input logic al);
        t_item it;
        it.func = FUNC_EVENT;
        it.slave_addr = 7'($urandom);
        it.tx_count = 8'($urandom);
        it.rx_count = 8'($urandom);
        it.tx_byte = 8'($urandom);
        it.rx_data = rxd;
        it.bus_error = be;
        it.arb_lost = al;
        return it;
    endfunction

    // one input beat, with a random gap ahead of it
    task automatic send_beat(input t_item it);
        int n;
        n = calm ? 0 : idle_len();
        if (n > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        beat_in <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        beats_sent++;
    endtask

    // hold the sender until every owed command has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // receiver stalls
    always @(negedge clk) begin
        int n;
        if (out_hold != 0) begin
            out_hold <= out_hold - 1;
        end else begin
            n = calm ? 0 : idle_len();
            out_ready <= (n == 0);
            out_hold <= (n == 0) ? 0 : n - 1;
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int         sel;
        int         n_events;
        int         tc;
        logic [7:0] txc;
        logic [7:0] rxc;

        // reset
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // stray event straight after reset
        send_beat(event_beat(8'h00, 1'b0, 1'b0));
        // single write byte, send only, top address
        send_beat(start_beat(7'h7F, 8'd1, 8'd0, 8'hFF));
        send_beat(event_beat(8'hFF, 1'b0, 1'b0));
        // zero write length, single read byte
        send_beat(start_beat(7'h00, 8'd0, 8'd1, 8'h00));
        send_beat(event_beat(8'h00, 1'b0, 1'b0));
        send_beat(event_beat(8'hFF, 1'b0, 1'b0));
        // two written, two read
        send_beat(start_beat(7'h55, 8'd2, 8'd2, 8'hA5));
        repeat (4) send_beat(event_beat(8'($urandom), 1'b0, 1'b0));
        // three written, three read: burst continue on both paths
        send_beat(start_beat(7'h2A, 8'd3, 8'd3, 8'h5A));
        repeat (6) send_beat(event_beat(8'($urandom), 1'b0, 1'b0));
        // longest lengths, cut short by a new start
        send_beat(start_beat(7'h7F, 8'd255, 8'd255, 8'($urandom)));
        send_beat(event_beat(8'($urandom), 1'b0, 1'b0));
        // bus error while writing, then a clean event with the error still held
        send_beat(start_beat(7'h11, 8'd2, 8'd5, 8'($urandom)));
        send_beat(event_beat(8'($urandom), 1'b1, 1'b0));
        send_beat(event_beat(8'($urandom), 1'b0, 1'b0));
        // both errors at the read restart
        send_beat(start_beat(7'h22, 8'd1, 8'd2, 8'($urandom)));
        send_beat(event_beat(8'($urandom), 1'b1, 1'b1));

        drain();

        // random transactions, some cut short, some noise
        while (beats_sent < RANDOM_BEATS) begin
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 1) == 0)
                        send_beat(start_beat(7'($urandom), 8'($urandom), 8'($urandom),
                                             8'($urandom)));
                    else
                        send_beat(event_beat(8'($urandom), 1'($urandom), 1'($urandom)));
                end
            end else begin
                txc = pick_len();
                rxc = pick_len();
                tc = (txc == 8'd0) ? 1 : int'(txc);
                n_events = (tc - 1) + ((rxc == 8'd0) ? 1 : int'(rxc) + 1);
                if (sel < 20) n_events = $urandom_range(0, n_events);
                // keep the run close to its beat budget
                if (n_events > RANDOM_BEATS - beats_sent)
                    n_events = RANDOM_BEATS - beats_sent;
                send_beat(start_beat(7'($urandom), txc, rxc, 8'($urandom)));
                for (int i = 0; i < n_events; i++)
                    send_beat(event_beat(8'($urandom), $urandom_range(0, 99) < 2,
                                         $urandom_range(0, 99) < 2));
                if ($urandom_range(0, 3) == 0)
                    send_beat(event_beat(8'($urandom), 1'b0, 1'b0));
            end
            if ($urandom_range(0, 15) == 0) drain();
            if ($urandom_range(0, 7) == 0) calm = ~calm;
        end

        // let the last commands come back
        drain();
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
